>>> hdl/binary_trie_lpm_lookup_assert.svh
// Assertion macros for the binary trie LPM lookup block.
`ifndef BINARY_TRIE_LPM_LOOKUP_ASSERT_SVH
`define BINARY_TRIE_LPM_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BTL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btl assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BTL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btl assertion failed");

`endif

>>> hdl/btl_pkg.sv
// Types and constants shared by the binary trie LPM lookup block.
`default_nettype none

package btl_pkg;

  // Stream widths (fields packed from bit 0, padded to whole bytes).
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 48;

  // Address geometry.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LAST_BIT = 31;
  localparam logic [5:0]  MAX_LEN  = 6'd32;

  // Operation codes (tuser).
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Route stored at a trie node.
  typedef struct packed {
    logic        valid;
    logic [31:0] hop;
    logic [7:0]  port;
  } route_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_ALLOC = 5'b00100,
    ST_READ  = 5'b01000,
    ST_FIN   = 5'b10000
  } btl_state_e;

endpackage

`default_nettype wire

>>> hdl/btl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module btl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/binary_trie_lpm_lookup.sv
// Top level of the IPv4 longest-prefix-match engine on a binary unibit trie.
//
//  channel | dir | payload                                         | handshake
//  s_axis  | in  | tuser: func; tdata: addr, prefix_len, route_hop, | tvalid/tready
//          |     |   out_port                                      |
//  m_axis  | out | tdata: found, hop_addr, port_num, status         | tvalid/tready
//
// Lookup: one trie level per cycle through the node RAM read port, up to 33
// levels, then the result is handed to the output register.
// Insert: existing levels are walked alike; each new node is linked to its parent,
// zeroed and reread, then the route is stored and the result is handed off.
// Reset: root node and free counter live in flops, other nodes are zeroed as
// they are allocated; ready from the first cycle after reset. Output stalls hold.
`default_nettype none
`include "binary_trie_lpm_lookup_assert.svh"

module binary_trie_lpm_lookup #(
  parameter int unsigned NODES = 4096
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [31:0] addr, [37:32] prefix_len, [69:38] route_hop, [77:70] out_port
  input  wire logic [btl_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [0] func
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [0] found, [32:1] hop_addr, [40:33] port_num, [41] status
  output logic      [btl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  import btl_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned RW = $bits(route_t);
  localparam int unsigned EW = RW + 2 * NW;
  localparam logic [NW:0] NodesCnt = (NW + 1)'(NODES);

  // Sequencer and walk state
  btl_state_e    state_q, state_d;
  logic [NW-1:0] node_q, node_d;
  logic [5:0]    depth_q, depth_d;
  logic [31:0]   addr_q, addr_d;
  logic [NW:0]   free_q, free_d;

  // Root node kept in flops so reset clears it at once
  logic [NW-1:0] root_c0_q, root_c0_d, root_c1_q, root_c1_d;
  route_t        root_rt_q, root_rt_d;

  // Request payload
  logic          func_q;
  logic [5:0]    len_q;
  logic [31:0]   hop_in_q;
  logic [7:0]    port_in_q;

  // Result being built
  logic          res_hit_q, res_hit_d, res_full_q, res_full_d;
  logic [31:0]   res_hop_q, res_hop_d;
  logic [7:0]    res_port_q, res_port_d;

  // Output register
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // Node RAM
  logic          ram_we;
  logic [NW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // Current node view
  logic [NW-1:0] ent_c0, ent_c1, nxt, new_node;
  route_t        ent_rt, new_rt;
  logic          dir, accept;
  logic [5:0]    in_len;

  btl_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Saturate prefix length to 32
  assign in_len = (s_axis_tdata_i[37:32] > MAX_LEN) ? MAX_LEN : s_axis_tdata_i[37:32];

  // Node 0 comes from flops, others from the RAM read issued last cycle
  always_comb begin
    if (node_q == '0) begin
      ent_c0 = root_c0_q;
      ent_c1 = root_c1_q;
      ent_rt = root_rt_q;
    end else begin
      ent_c0 = ram_rdata[NW-1:0];
      ent_c1 = ram_rdata[2*NW-1:NW];
      ent_rt = route_t'(ram_rdata[EW-1:2*NW]);
    end
  end

  assign dir      = addr_q[LAST_BIT];
  assign nxt      = dir ? ent_c1 : ent_c0;
  assign new_node = free_q[NW-1:0];
  assign new_rt   = '{valid: 1'b1, hop: hop_in_q, port: port_in_q};

  // Sequencer
  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    depth_d    = depth_q;
    addr_d     = addr_q;
    free_d     = free_q;
    root_c0_d  = root_c0_q;
    root_c1_d  = root_c1_q;
    root_rt_d  = root_rt_q;
    res_hit_d  = res_hit_q;
    res_full_d = res_full_q;
    res_hop_d  = res_hop_q;
    res_port_d = res_port_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    ram_we     = 1'b0;
    ram_waddr  = node_q;
    ram_wdata  = '0;
    ram_raddr  = node_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          node_d     = '0;
          depth_d    = '0;
          addr_d     = s_axis_tdata_i[31:0];
          res_hit_d  = 1'b0;
          res_full_d = STAT_OK;
          res_hop_d  = '0;
          res_port_d = '0;
          state_d    = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (func_q == FUNC_LOOKUP) begin
          // Keep the deepest route passed
          if (ent_rt.valid) begin
            res_hit_d  = 1'b1;
            res_hop_d  = ent_rt.hop;
            res_port_d = ent_rt.port;
          end
          if ((depth_q == MAX_LEN) || (nxt == '0)) begin
            state_d = ST_FIN;
          end else begin
            ram_raddr = nxt;
            node_d    = nxt;
            depth_d   = depth_q + 6'd1;
            addr_d    = {addr_q[LAST_BIT-1:0], 1'b0};
          end
        end else if (depth_q == len_q) begin
          // End of prefix: store the route here
          if (node_q == '0) begin
            root_rt_d = new_rt;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {new_rt, ent_c1, ent_c0};
          end
          state_d = ST_FIN;
        end else if (nxt != '0) begin
          ram_raddr = nxt;
          node_d    = nxt;
          depth_d   = depth_q + 6'd1;
          addr_d    = {addr_q[LAST_BIT-1:0], 1'b0};
        end else if (free_q == NodesCnt) begin
          res_full_d = STAT_FULL;
          state_d    = ST_FIN;
        end else begin
          // Link a fresh node into the parent
          if (node_q == '0) begin
            if (dir) root_c1_d = new_node;
            else     root_c0_d = new_node;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = dir ? {ent_rt, new_node, ent_c0} : {ent_rt, ent_c1, new_node};
          end
          free_d  = free_q + (NW + 1)'(1);
          node_d  = new_node;
          depth_d = depth_q + 6'd1;
          addr_d  = {addr_q[LAST_BIT-1:0], 1'b0};
          state_d = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        // Zero the new node's links and route
        ram_we    = 1'b1;
        ram_wdata = '0;
        state_d   = ST_READ;
      end

      ST_READ: begin
        ram_raddr = node_q;
        state_d   = ST_EVAL;
      end

      ST_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, res_full_q, res_port_q, res_hop_q, res_hit_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      node_q    <= '0;
      depth_q   <= '0;
      addr_q    <= '0;
      free_q    <= (NW + 1)'(1);
      root_c0_q <= '0;
      root_c1_q <= '0;
      root_rt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      node_q    <= node_d;
      depth_q   <= depth_d;
      addr_q    <= addr_d;
      free_q    <= free_d;
      root_c0_q <= root_c0_d;
      root_c1_q <= root_c1_d;
      root_rt_q <= root_rt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= s_axis_tuser_i;
      len_q     <= in_len;
      hop_in_q  <= s_axis_tdata_i[69:38];
      port_in_q <= s_axis_tdata_i[77:70];
    end
    res_hit_q  <= res_hit_d;
    res_full_q <= res_full_d;
    res_hop_q  <= res_hop_d;
    res_port_q <= res_port_d;
    m_data_q   <= m_data_d;
  end

  // Checks
  `BTL_ASSERT_IMP(a_free_range, 1'b1, (free_q != '0) && (free_q <= NodesCnt))
  `BTL_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ST_IDLE)
  `BTL_ASSERT_IMP(a_out_from_fin, $rose(m_valid_q), $past(state_q) == ST_FIN)
  `BTL_ASSERT_IMP(a_depth_bound, state_q == ST_EVAL, depth_q <= MAX_LEN)
  `BTL_ASSERT_IMP(a_hit_not_full, m_valid_q && m_data_q[0], m_data_q[41] == STAT_OK)

endmodule

`default_nettype wire

>>> tb/btl_route_checker.sv
// Checker for the trie LPM engine: tracks the route table and scores every result.
`timescale 1ns / 1ps

module btl_route_checker
  import btl_pkg::*;
#(
  parameter int unsigned NODES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  typedef struct {
    logic        found;
    logic [31:0] hop;
    logic [7:0]  port;
    logic        status;
  } lpm_reply_t;

  // Shadow trie: child index per direction, route per node, allocation pointer
  int unsigned links [NODES][2];
  route_t      routes[NODES];
  int unsigned free_next;

  lpm_reply_t reply_q[$];

  // Walk the prefix, allocating nodes as needed; 0 when the store runs out
  function automatic logic trie_insert(logic [31:0] pfx, logic [5:0] len_in, route_t r);
    int unsigned node;
    int unsigned nxt;
    int unsigned depth;
    int unsigned lim;
    logic        dir;
    node = 0;
    lim  = (len_in > MAX_LEN) ? ADDR_W : len_in;
    for (depth = 0; depth < lim; depth++) begin
      dir = pfx[LAST_BIT - depth];
      nxt = links[node][dir];
      if (nxt == 0) begin
        if (free_next >= NODES) return 1'b0;
        nxt = free_next;
        free_next++;
        links[nxt][0] = 0;
        links[nxt][1] = 0;
        routes[nxt] = '0;
        links[node][dir] = nxt;
      end
      node = nxt;
    end
    routes[node] = r;
    return 1'b1;
  endfunction

  // Deepest valid route along the address path, root and depth 32 included
  function automatic route_t trie_search(logic [31:0] ip);
    int unsigned node;
    int unsigned depth;
    route_t      best;
    node = 0;
    best = '0;
    for (depth = 0; depth <= ADDR_W; depth++) begin
      if (routes[node].valid) best = routes[node];
      if (depth == ADDR_W) break;
      node = links[node][ip[LAST_BIT - depth]];
      if (node == 0) break;
    end
    return best;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      fail_count_o++;
    end
  endtask

  // Results are scored before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lpm_reply_t  exp_r;
    route_t      hit;
    route_t      new_route;
    logic        ok;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        links[i][0] = 0;
        links[i][1] = 0;
        routes[i]   = '0;
      end
      free_next = 1;
      reply_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, m_tdata_i);
          fail_count_o++;
        end else begin
          exp_r = reply_q.pop_front();
          check_field("found", exp_r.found, m_tdata_i[0]);
          check_field("hop_addr", exp_r.hop, m_tdata_i[32:1]);
          check_field("port_num", exp_r.port, m_tdata_i[40:33]);
          check_field("status", exp_r.status, m_tdata_i[41]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == FUNC_INSERT) begin
          new_route.valid = 1'b1;
          new_route.hop   = s_tdata_i[69:38];
          new_route.port  = s_tdata_i[77:70];
          ok = trie_insert(s_tdata_i[31:0], s_tdata_i[37:32], new_route);
          exp_r.found  = 1'b0;
          exp_r.hop    = '0;
          exp_r.port   = '0;
          exp_r.status = ok ? STAT_OK : STAT_FULL;
        end else begin
          hit = trie_search(s_tdata_i[31:0]);
          exp_r.found  = hit.valid;
          exp_r.hop    = hit.hop;
          exp_r.port   = hit.port;
          exp_r.status = STAT_OK;
        end
        reply_q.push_back(exp_r);
      end
      pending_o = reply_q.size();
    end
  end

endmodule

>>> tb/binary_trie_lpm_lookup_tb.sv
// Testbench top for the trie LPM engine: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module binary_trie_lpm_lookup_tb;
  import btl_pkg::*;

  localparam int unsigned NODE_COUNT = 4096;

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tuser  = FUNC_INSERT;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int unsigned            fail_count;
  int unsigned            pending;

  // Prefixes sent so far, length saturated at 32, used to aim lookups
  logic [31:0] known_addr[$];
  int unsigned known_len[$];
  int unsigned burst_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left  = 0;

  always #4 clk = ~clk;

  binary_trie_lpm_lookup #(.NODES(NODE_COUNT)) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  btl_route_checker #(.NODES(NODE_COUNT)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side backpressure: always ready, light random stalls, or long stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready   <= 1'b0;
      ready_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          m_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Burst pacing: called right after an accept, may drop valid for a gap
  task automatic pace();
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drive one request and hold it until accepted; valid stays high afterwards
  task automatic send_req(input logic f, input logic [31:0] a, input logic [5:0] l,
                          input logic [31:0] h, input logic [7:0] p);
    pace();
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {2'b00, p, h, l, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic add_route(input logic [31:0] a, input logic [5:0] l,
                           input logic [31:0] h, input logic [7:0] p);
    send_req(FUNC_INSERT, a, l, h, p);
    known_addr.push_back(a);
    known_len.push_back((l > MAX_LEN) ? ADDR_W : l);
  endtask

  // Lookup with the unused fields randomized
  task automatic probe_addr(input logic [31:0] a);
    send_req(FUNC_LOOKUP, a, 6'($urandom_range(0, 63)), $urandom(), 8'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Keep the top len bits of a, randomize the rest
  function automatic logic [31:0] spread(logic [31:0] a, int unsigned len);
    logic [31:0] keep;
    if (len >= ADDR_W) keep = '1;
    else if (len == 0) keep = '0;
    else keep = ~(32'hFFFF_FFFF >> len);
    return (a & keep) | ($urandom() & ~keep);
  endfunction

  function automatic logic [5:0] random_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 6'($urandom_range(0, 7));
    if (roll < 60) return 6'($urandom_range(8, 24));
    if (roll < 85) return 6'($urandom_range(25, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  // Mixed traffic; fill_store leans on long fresh routes to exhaust the node store
  task automatic random_phase(input int unsigned count, input bit fill_store);
    int unsigned n;
    int unsigned roll;
    int unsigned pick;
    logic [31:0] a;
    logic [5:0]  l;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, known_addr.size() - 1);
      roll = $urandom_range(0, 99);
      if (roll < (fill_store ? 60 : 45)) begin
        roll = $urandom_range(0, 99);
        if (fill_store && roll < 70) begin
          a = $urandom();
          l = MAX_LEN;
        end else if (roll < 15) begin
          // same prefix again: overwrite
          l = 6'(known_len[pick]);
          a = spread(known_addr[pick], known_len[pick]);
        end else if (roll < 50) begin
          // more specific route under a known one
          l = 6'($urandom_range(known_len[pick], ADDR_W));
          a = spread(known_addr[pick], known_len[pick]);
        end else begin
          a = $urandom();
          l = random_len();
        end
        if (l == MAX_LEN && $urandom_range(0, 9) == 0) l = 6'($urandom_range(33, 63));
        add_route(a, l, $urandom(), 8'($urandom_range(0, 255)));
      end else begin
        roll = $urandom_range(0, 99);
        a = spread(known_addr[pick], known_len[pick]);
        if (roll >= 60 && roll < 75 && known_len[pick] != 0) begin
          // sibling of a known prefix
          a[ADDR_W - known_len[pick]] = ~a[ADDR_W - known_len[pick]];
        end else if (roll >= 75) begin
          a = $urandom();
        end
        probe_addr(a);
      end
    end
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, default route, host routes at both ends,
    // nesting, saturated lengths, overwrite, ignored lookup fields
    probe_addr(32'h0000_0000);
    probe_addr(32'hFFFF_FFFF);
    add_route(32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 8'hFF);
    probe_addr(32'h1234_5678);
    add_route(32'hFFFF_FFFF, 6'd32, 32'hA5A5_A5A5, 8'h5A);
    probe_addr(32'hFFFF_FFFF);
    probe_addr(32'hFFFF_FFFE);
    add_route(32'h0000_0000, 6'd32, 32'h0000_0000, 8'h00);
    probe_addr(32'h0000_0000);
    add_route(32'h0AFF_FFFF, 6'd8, 32'h0A00_0001, 8'h01);
    add_route(32'h0A01_FFFF, 6'd16, 32'h0A01_0001, 8'h02);
    probe_addr(32'h0A01_0203);
    probe_addr(32'h0A02_0000);
    add_route(32'hC0A8_0101, 6'd63, 32'hC0A8_0001, 8'h03);
    add_route(32'hC0A8_0102, 6'd33, 32'hC0A8_0002, 8'h04);
    probe_addr(32'hC0A8_0101);
    probe_addr(32'hC0A8_0102);
    probe_addr(32'hC0A8_0103);
    add_route(32'h0A00_0000, 6'd8, 32'h5555_5555, 8'hAA);
    probe_addr(32'h0AC8_0000);
    add_route(32'h8000_0000, 6'd1, 32'hAAAA_AAAA, 8'h55);
    add_route(32'h7FFF_FFFE, 6'd31, 32'h1234_5678, 8'h80);
    send_req(FUNC_LOOKUP, 32'h7FFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
    probe_addr(32'h8000_0001);
    drain();

    random_phase(440, 1'b0);
    drain();
    random_phase(190, 1'b1);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/btl_pkg.sv
hdl/btl_ram.sv
hdl/binary_trie_lpm_lookup.sv
tb/btl_route_checker.sv
tb/binary_trie_lpm_lookup_tb.sv
